>>> sv/wsfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser package
// Shared types, codes and helper functions for the header parser.
// ----------------------------------------------------------------------------
package wsfh_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned LengthW = 64;
  localparam int unsigned KeyW    = 32;

  localparam int unsigned FinBit  = 7;
  localparam int unsigned MaskBit = 7;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  localparam logic [CountW-1:0] BaseHeader = 4'd2;
  localparam logic [CountW-1:0] KeyBytes   = 4'd4;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_ERROR      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LK_SHORT = 2'd0,
    LK_EXT16 = 2'd1,
    LK_EXT64 = 2'd2
  } length_kind_e;

  typedef struct packed {
    logic [CountW-1:0]  header_count;
    length_kind_e       length_kind;
    logic               fin;
    logic [OpcodeW-1:0] opcode;
    logic [LengthW-1:0] length;
    logic [KeyW-1:0]    key;
    logic [LengthW-1:0] payload_seen;
    logic               error;
  } parse_state_t;

  typedef struct packed {
    status_e            status;
    logic               final_fragment;
    logic [OpcodeW-1:0] frame_opcode;
    logic [LengthW-1:0] payload_length;
    logic [KeyW-1:0]    mask_key;
    logic [CountW-1:0]  header_length;
  } result_t;

  // Extended length bytes that follow byte 1.
  function automatic logic [CountW-1:0] ext_bytes(length_kind_e kind);
    logic [CountW-1:0] n;
    case (kind)
      LK_EXT16: n = 4'd2;
      LK_EXT64: n = 4'd8;
      default:  n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [CountW-1:0] header_len(length_kind_e kind);
    return BaseHeader + ext_bytes(kind) + KeyBytes;
  endfunction

endpackage

>>> sv/wsfh_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket header parser step logic
// Next parser state and the result for one received byte.
// ----------------------------------------------------------------------------
module wsfh_step (
  input  wsfh_pkg::parse_state_t state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   frame_start_i,
  output wsfh_pkg::parse_state_t state_o,
  output wsfh_pkg::result_t      result_o
);

  wsfh_pkg::parse_state_t          cur;
  wsfh_pkg::parse_state_t          nxt;
  wsfh_pkg::status_e               status;
  logic                            done;
  logic [wsfh_pkg::CountW-1:0]     cnt_inc;
  logic [wsfh_pkg::LengthW-1:0]    seen_inc;
  logic [6:0]                      len7;

  assign cur      = frame_start_i ? '0 : state_i;
  assign cnt_inc  = cur.header_count + 4'd1;
  assign seen_inc = (&cur.payload_seen) ? cur.payload_seen : cur.payload_seen + 64'd1;
  assign len7     = data_byte_i[6:0];

  always_comb begin
    nxt    = cur;
    status = wsfh_pkg::ST_INCOMPLETE;
    done   = 1'b0;
    if (cur.error) begin
      // sticky until the next frame_start
      status = wsfh_pkg::ST_ERROR;
    end else if (cur.header_count == 4'd0) begin
      nxt.fin          = data_byte_i[wsfh_pkg::FinBit];
      nxt.opcode       = data_byte_i[wsfh_pkg::OpcodeW-1:0];
      nxt.header_count = 4'd1;
    end else if (cur.header_count == 4'd1) begin
      if (!data_byte_i[wsfh_pkg::MaskBit]) begin
        nxt.error = 1'b1;
        status    = wsfh_pkg::ST_ERROR;
      end
      if (len7 == wsfh_pkg::Len16Code) begin
        nxt.length_kind = wsfh_pkg::LK_EXT16;
        nxt.length      = '0;
      end else if (len7 == wsfh_pkg::Len64Code) begin
        nxt.length_kind = wsfh_pkg::LK_EXT64;
        nxt.length      = '0;
      end else begin
        nxt.length_kind = wsfh_pkg::LK_SHORT;
        nxt.length      = {57'd0, len7};
      end
      nxt.header_count = 4'd2;
    end else if (cur.header_count < wsfh_pkg::header_len(cur.length_kind)) begin
      if (cur.header_count < wsfh_pkg::BaseHeader + wsfh_pkg::ext_bytes(cur.length_kind)) begin
        nxt.length = {cur.length[55:0], data_byte_i};
      end else begin
        nxt.key = {cur.key[23:0], data_byte_i};
      end
      nxt.header_count = cnt_inc;
      // empty payload completes on the last key byte
      done = (cnt_inc == wsfh_pkg::header_len(cur.length_kind)) && (nxt.length == '0);
    end else begin
      nxt.payload_seen = seen_inc;
      done = (seen_inc >= cur.length);
    end
    if (done) begin
      status = wsfh_pkg::ST_COMPLETE;
    end
  end

  always_comb begin
    result_o.status         = status;
    result_o.final_fragment = nxt.fin;
    result_o.frame_opcode   = nxt.opcode;
    result_o.payload_length = nxt.length;
    result_o.mask_key       = nxt.key;
    result_o.header_length  = wsfh_pkg::header_len(nxt.length_kind);
  end

  assign state_o = done ? '0 : nxt;

endmodule

>>> sv/websocket_frame_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser
// Byte-wide frame header decoder with payload byte counting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per request (data_byte_i), with
//   frame_start_i marking the first byte of a frame and clearing the parser.
//   Output channel: one result per input byte carrying status (incomplete,
//   complete, unmasked error), FIN, opcode, payload length, mask key and
//   the header length (6, 8 or 14).
//   The result of a byte is valid in the cycle after it is taken. Throughput
//   is one byte per cycle while the output is not stalled; the parser state
//   and the output register are updated by a single pass of step logic.
//   After reset the parser waits for byte 0 of a frame and the output is
//   empty. When the receiver stalls, the result register holds and the
//   input stalls only while that register is full and not being taken.
//   After a complete frame the parser clears itself, so the next byte is
//   byte 0 of the next frame.
// ----------------------------------------------------------------------------
module websocket_frame_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        final_fragment_o,
  output logic [3:0]  frame_opcode_o,
  output logic [63:0] payload_length_o,
  output logic [31:0] mask_key_o,
  output logic [3:0]  header_length_o
);

  wsfh_pkg::parse_state_t state_q;
  wsfh_pkg::parse_state_t state_d;
  wsfh_pkg::result_t      result_q;
  wsfh_pkg::result_t      result_d;
  logic                   out_valid_q;
  logic                   out_valid_d;
  logic                   in_accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  wsfh_step u_step (
    .state_i       (state_q),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = result_q.status;
  assign final_fragment_o = result_q.final_fragment;
  assign frame_opcode_o   = result_q.frame_opcode;
  assign payload_length_o = result_q.payload_length;
  assign mask_key_o       = result_q.mask_key;
  assign header_length_o  = result_q.header_length;

endmodule

>>> sv/wsfh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket header parser port checker
// Port-level properties of the header parser, bound to the top level.
// ----------------------------------------------------------------------------
module wsfh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [3:0]  header_length_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // every accepted request produces a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no result");

  // input only stalls behind a stalled full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_hdr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> header_length_o == 4'd6 || header_length_o == 4'd8 ||
                    header_length_o == 4'd14)
    else $error("bad header length");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status code");

endmodule

bind websocket_frame_header_parser wsfh_checker u_wsfh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .header_length_o (header_length_o)
);
